@@ rtl/core/bihr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the beat-interval heart-rate meter.
// No dependencies; used by every module of the block.
package bihr_pkg;

  localparam int SMP_W  = 24;
  localparam int TIME_W = 32;
  localparam int TPM_W  = 32;
  localparam int BEAT_W = 6;
  localparam int RATE_W = 16;
  localparam int NUM_W  = TPM_W + BEAT_W;
  localparam int IDX_W  = 8;

  localparam logic [BEAT_W-1:0] MAX_BEATS = 6'd32;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_SMP  = 2'd1;
  localparam logic [1:0] FUNC_FIN  = 2'd2;

  localparam logic [IDX_W-1:0] CFG_THR = 8'd0;
  localparam logic [IDX_W-1:0] CFG_TPM = 8'd1;

  localparam logic [SMP_W-1:0] THR_RST = 24'd10000;
  localparam logic [TPM_W-1:0] TPM_RST = 32'd60000000;

  typedef struct packed {
    logic start;
    logic ok;
    logic ack;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic              rate_valid;
    logic [RATE_W-1:0] rate;
  } div_sts_t;

endpackage

@@ rtl/core/bihr_div.sv @@
`timescale 1ns / 1ps
// Rate unit: one multiply, a saturation check, then a 16-step restoring divide on a shared subtractor.
// Depends on bihr_pkg.
module bihr_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bihr_pkg::div_req_t           req,
  input  logic [bihr_pkg::TPM_W-1:0]   tpm,
  input  logic [bihr_pkg::BEAT_W-1:0]  bm1,
  input  logic [bihr_pkg::TIME_W-1:0]  span,
  output bihr_pkg::div_sts_t           sts
);
  import bihr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [TPM_W-1:0]  tpm_r, tpm_nxt;
  logic [BEAT_W-1:0] bm1_r, bm1_nxt;
  logic [TIME_W-1:0] span_r, span_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [RATE_W-1:0] q_r, q_nxt;
  logic              ok_r, ok_nxt;
  logic [TIME_W:0]   trial;
  logic              ge;
  logic [RATE_W-1:0] num_lo;
  logic [TIME_W-1:0] num_hi;

  assign num_lo = num_r[RATE_W-1:0];
  assign num_hi = {{(TIME_W-(NUM_W-RATE_W)){1'b0}}, num_r[NUM_W-1:RATE_W]};
  assign trial  = {rem_r, num_lo[cnt_r]};
  assign ge     = trial >= {1'b0, span_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    tpm_nxt   = tpm_r;
    bm1_nxt   = bm1_r;
    span_nxt  = span_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    ok_nxt    = ok_r;
    case (state_r)
      S_IDLE: begin
        if (req.start) begin
          tpm_nxt  = tpm;
          bm1_nxt  = bm1;
          span_nxt = span;
          ok_nxt   = req.ok;
          q_nxt    = '0;
          state_nxt = req.ok ? S_MUL : S_DONE;
        end
      end
      S_MUL: begin
        num_nxt   = {{BEAT_W{1'b0}}, tpm_r} * {{TPM_W{1'b0}}, bm1_r};
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (num_hi >= span_r) begin
          q_nxt     = '1;
          state_nxt = S_DONE;
        end else begin
          rem_nxt   = num_hi;
          cnt_nxt   = 4'd15;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = ge ? TIME_W'(trial - {1'b0, span_r}) : trial[TIME_W-1:0];
        q_nxt   = {q_r[RATE_W-2:0], ge};
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (req.ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    tpm_r  <= tpm_nxt;
    bm1_r  <= bm1_nxt;
    span_r <= span_nxt;
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    ok_r   <= ok_nxt;
  end

  assign sts.busy       = state_r != S_IDLE;
  assign sts.done       = state_r == S_DONE;
  assign sts.rate_valid = ok_r;
  assign sts.rate       = q_r;

endmodule

@@ rtl/core/beat_interval_heart_rate.sv @@
`timescale 1ns / 1ps
// Top level of the beat-interval heart-rate meter: item decode, beat capture, output register.
// Depends on bihr_pkg and bihr_div.
//
// Tick and sample items may arrive back to back while the rate unit is idle. A finish item
// hands the beat count and span to the rate unit and clears the timing state at once;
// in_tready then stays low until the result has moved into the output register. An
// invalid rate goes straight to the load; otherwise come one multiply, one saturation
// check, sixteen restoring-divide steps on one 33-bit subtractor unless the rate saturates,
// and the load, which waits while a previous result still waits on out_tready.
// Ticks and samples are accepted while a finished result waits in the output register.
module beat_interval_heart_rate (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [23:0]                 in_tdata,   // [23:0] sample
  input  logic [1:0]                  in_tuser,   // [1:0] func
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,  // [15:0] heart_rate_bpm
  output logic [0:0]                  out_tuser,  // [0] rate_valid
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bihr_pkg::IDX_W-1:0]  cfg_index,
  input  logic [31:0]                 cfg_data
);
  import bihr_pkg::*;

  logic [SMP_W-1:0]  thr_r;
  logic [TPM_W-1:0]  tpm_r;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [SMP_W-1:0]  prev_r, prev_nxt;
  logic [BEAT_W-1:0] cnt_r, cnt_nxt;
  logic [TIME_W-1:0] first_r, first_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [RATE_W-1:0] out_rate_r;
  logic              out_ok_r;
  logic              in_acc;
  logic              out_load;
  logic [SMP_W:0]    smp_sum;
  logic              beat;
  logic [TIME_W-1:0] span;
  div_req_t          req;
  div_sts_t          sts;

  assign cfg_ready = 1'b1;
  assign in_tready = !sts.busy;
  assign in_acc    = in_tvalid && in_tready;

  assign smp_sum = {1'b0, in_tdata} + {1'b0, thr_r};
  assign beat    = {1'b0, prev_r} > smp_sum;
  assign span    = last_r - first_r;

  assign out_load = sts.done && (!out_valid_r || out_tready);

  always_comb begin
    time_nxt  = time_r;
    prev_nxt  = prev_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    req.start = 1'b0;
    req.ok    = (cnt_r >= 6'd2) && (span != '0);
    req.ack   = out_load;
    if (in_acc) begin
      case (in_tuser)
        FUNC_TICK: begin
          time_nxt = time_r + 32'd1;
        end
        FUNC_SMP: begin
          if (beat && cnt_r < MAX_BEATS) begin
            if (cnt_r == '0) begin
              first_nxt = time_r;
            end
            last_nxt = time_r;
            cnt_nxt  = cnt_r + 6'd1;
          end
          prev_nxt = in_tdata;
        end
        FUNC_FIN: begin
          req.start = 1'b1;
          time_nxt  = '0;
          prev_nxt  = '0;
          cnt_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  bihr_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .tpm  (tpm_r),
    .bm1  (cnt_r - 6'd1),
    .span (span),
    .sts  (sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THR_RST;
      tpm_r       <= TPM_RST;
      time_r      <= '0;
      prev_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THR: thr_r <= cfg_data[SMP_W-1:0];
          CFG_TPM: tpm_r <= cfg_data;
          default: begin
          end
        endcase
      end
      time_r      <= time_nxt;
      prev_r      <= prev_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    last_r  <= last_nxt;
    if (out_load) begin
      out_rate_r <= sts.rate;
      out_ok_r   <= sts.rate_valid;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_rate_r;
  assign out_tuser[0] = out_ok_r;

endmodule

@@ rtl/core/bihr_check.sv @@
`timescale 1ns / 1ps
// Port-level checks for the beat-interval heart-rate meter, bound to the top level.
// Depends on bihr_pkg and beat_interval_heart_rate.
module bihr_check (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [1:0]                  in_tuser,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [15:0]                 out_tdata,
  input logic [0:0]                  out_tuser,
  input logic                        cfg_ready
);
  import bihr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result item changed");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 16'd0)
    else $error("invalid rate carries nonzero value");

  a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == FUNC_FIN |=> !in_tready)
    else $error("finish item did not stall the input");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready && cfg_ready)
    else $error("wrong port state after reset");

endmodule

bind beat_interval_heart_rate bihr_check u_bihr_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .cfg_ready (cfg_ready)
);

@@ test/beat_interval_heart_rate_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for beat_interval_heart_rate: ticks, ECG samples and finish items
// are sent while an internal heart-rate predictor computes each expected rate item.
// Depends on bihr_pkg and the beat_interval_heart_rate RTL.
module beat_interval_heart_rate_tb;
  import bihr_pkg::*;

  localparam logic [1:0]       FUNC_NONE   = 2'd3;
  localparam logic [IDX_W-1:0] CFG_SPARE   = 8'd2;
  localparam logic [IDX_W-1:0] CFG_TOP     = 8'hFF;
  localparam logic [23:0]      SMP_FULL    = 24'hFFFFFF;
  localparam int               HOLD_CYCLES = 400;
  localparam int               SETTLE_CYC  = 30;
  localparam int               DRAIN_LIMIT = 5000;
  localparam int               RAND_ITEMS  = 1450;

  typedef struct packed {
    logic [15:0] bpm;
    logic        ok;
  } rate_rec_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [23:0]      in_tdata = '0;   // [23:0] sample
  logic [1:0]       in_tuser = '0;   // [1:0] func
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [15:0]      out_tdata;       // [15:0] heart_rate_bpm
  logic [0:0]       out_tuser;       // [0] rate_valid
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [31:0]      cfg_data = '0;

  // predictor state and registers
  logic [31:0] ts_now = '0;
  logic [23:0] prev_smp = '0;
  logic [5:0]  n_beats = '0;
  logic [31:0] t_first = '0;
  logic [31:0] t_last = '0;
  logic [23:0] thr_reg = THR_RST;
  logic [31:0] tpm_reg = TPM_RST;

  rate_rec_t rate_q[$];
  rate_rec_t rate_exp;
  int        errors = 0;
  int        n_items = 0;
  bit        no_idle = 1'b0;
  bit        hold_go = 1'b0;
  int        hold_left = 0;

  beat_interval_heart_rate dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(99, 0) >= 28);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (rate_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: rate item with none pending: bpm %0d valid %0b",
                   $realtime, out_tdata, out_tuser[0]);
      end else begin
        rate_exp = rate_q.pop_front();
        if (out_tdata !== rate_exp.bpm || out_tuser[0] !== rate_exp.ok) begin
          errors++;
          if (errors <= 10)
            $display("%0t: rate mismatch: expected bpm %0d valid %0b, got bpm %0d valid %0b",
                     $realtime, rate_exp.bpm, rate_exp.ok, out_tdata, out_tuser[0]);
        end
      end
    end
  end

  task automatic predict_rate(input logic [1:0] f, input logic [23:0] s);
    logic [31:0] span;
    logic [63:0] quot;
    rate_rec_t   r;
    case (f)
      FUNC_TICK: ts_now = ts_now + 32'd1;
      FUNC_SMP: begin
        if ({1'b0, prev_smp} > {1'b0, s} + {1'b0, thr_reg} && n_beats < MAX_BEATS) begin
          if (n_beats == '0) t_first = ts_now;
          t_last = ts_now;
          n_beats = n_beats + 6'd1;
        end
        prev_smp = s;
      end
      FUNC_FIN: begin
        span = t_last - t_first;
        r.bpm = '0;
        r.ok = 1'b0;
        if (n_beats >= 6'd2 && span != '0) begin
          quot = (64'(tpm_reg) * 64'(n_beats - 6'd1)) / 64'(span);
          r.bpm = (quot > 64'hFFFF) ? 16'hFFFF : quot[15:0];
          r.ok = 1'b1;
        end
        rate_q.push_back(r);
        ts_now = '0;
        prev_smp = '0;
        n_beats = '0;
        t_first = '0;
        t_last = '0;
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [1:0] f, input logic [23:0] s);
    @(negedge clk);
    while (!no_idle && $urandom_range(99, 0) < 28) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = f;
    in_tdata = s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_rate(f, s);
    if (f != FUNC_NONE) n_items++;
  endtask

  // stop offering items, wait for every pending rate, then let the block go quiet
  task automatic drain;
    int guard;
    guard = 0;
    @(negedge clk);
    in_tvalid = 1'b0;
    while (rate_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_THR: thr_reg = d[23:0];
      CFG_TPM: tpm_reg = d;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // high/low sample pairs, each fall a beat unless thr_reg is full scale, random ticks between, then finish
  task automatic send_recording(input int nb, input int gap_max);
    int unsigned lo_max;
    logic [23:0] lo, hi;
    for (int b = 0; b < nb; b++) begin
      if ($urandom_range(9, 0) == 0) send_item(2'($urandom_range(3, 0)), 24'($urandom));
      if (thr_reg == SMP_FULL) begin
        hi = 24'($urandom);
        lo = 24'($urandom);
      end else begin
        lo_max = 32'(SMP_FULL) - 32'(thr_reg) - 1;
        lo = 24'($urandom_range(lo_max, 0));
        hi = 24'($urandom_range(32'(SMP_FULL), 32'(lo) + 32'(thr_reg) + 1));
      end
      send_item(FUNC_SMP, hi);
      repeat ($urandom_range(gap_max, 0)) send_item(FUNC_TICK, 24'($urandom));
      send_item(FUNC_SMP, lo);
    end
    repeat ($urandom_range(2, 0)) send_item(FUNC_TICK, 24'($urandom));
    send_item(FUNC_FIN, 24'($urandom));
  endtask

  task automatic test_directed;
    send_item(FUNC_FIN, SMP_FULL);
    send_item(FUNC_NONE, SMP_FULL);
    send_item(FUNC_SMP, 24'd0);
    send_item(FUNC_SMP, SMP_FULL);
    send_item(FUNC_SMP, 24'd0);
    send_item(FUNC_FIN, 24'd0);
    send_item(FUNC_SMP, SMP_FULL);
    send_item(FUNC_SMP, 24'd0);
    send_item(FUNC_SMP, SMP_FULL);
    send_item(FUNC_SMP, 24'd0);
    send_item(FUNC_FIN, 24'd0);
    send_item(FUNC_SMP, SMP_FULL);
    send_item(FUNC_SMP, 24'd0);
    send_item(FUNC_TICK, SMP_FULL);
    send_item(FUNC_SMP, SMP_FULL);
    send_item(FUNC_SMP, 24'd10000);
    send_item(FUNC_FIN, 24'h555555);
    drain();
  endtask

  task automatic test_threshold_edges;
    write_reg(CFG_THR, {8'hFF, SMP_FULL});
    write_reg(CFG_TPM, 32'd1);
    send_item(FUNC_SMP, SMP_FULL);
    send_item(FUNC_SMP, 24'd0);
    send_item(FUNC_FIN, 24'd0);
    drain();
    write_reg(CFG_THR, 32'd0);
    write_reg(CFG_TPM, 32'hFFFFFFFF);
    send_item(FUNC_SMP, 24'd5);
    send_item(FUNC_SMP, 24'd4);
    send_item(FUNC_SMP, 24'd4);
    send_item(FUNC_TICK, 24'd0);
    send_item(FUNC_TICK, 24'd0);
    send_item(FUNC_SMP, 24'd3);
    send_item(FUNC_FIN, 24'd0);
    drain();
    write_reg(CFG_TPM, 32'd1);
    write_reg(CFG_SPARE, $urandom);
    write_reg(CFG_TOP, $urandom);
    send_item(FUNC_SMP, 24'd5);
    send_item(FUNC_SMP, 24'd4);
    send_item(FUNC_TICK, 24'd0);
    send_item(FUNC_TICK, 24'd0);
    send_item(FUNC_SMP, 24'd3);
    send_item(FUNC_FIN, 24'd0);
    send_item(FUNC_SMP, 24'd9);
    send_item(FUNC_SMP, 24'd8);
    send_item(FUNC_TICK, 24'd0);
    send_item(FUNC_SMP, 24'd7);
    send_item(FUNC_FIN, 24'd0);
    drain();
  endtask

  task automatic test_backpressure;
    write_reg(CFG_THR, 32'd1000);
    write_reg(CFG_TPM, 32'd6000);
    hold_go = 1'b1;
    repeat (3) send_recording(4, 3);
    repeat (20) send_item(FUNC_TICK, 24'($urandom));
    drain();
  endtask

  task automatic test_random;
    logic [23:0] thr_set[5];
    logic [31:0] tpm_set[5];
    int          gap_set[5];
    int          base, r, nb;
    thr_set = '{24'd0, 24'd10000, 24'($urandom_range(16'hFFFF, 0)), 24'hFFFFFE,
                24'($urandom)};
    tpm_set = '{32'd1, TPM_RST, 32'($urandom_range(100000, 1000)), 32'hFFFFFFFF,
                32'($urandom_range(32'hFFFFFFFF, 1))};
    gap_set = '{3, 8, 6, 4, 5};
    base = n_items;
    for (int p = 0; p < 5; p++) begin
      drain();
      write_reg(CFG_THR, {8'($urandom), thr_set[p]});
      write_reg(CFG_TPM, tpm_set[p]);
      no_idle = (p == 2);
      while (n_items - base < (p + 1) * RAND_ITEMS / 5) begin
        r = $urandom_range(99, 0);
        if (r < 70) nb = $urandom_range(10, 0);
        else if (r < 90) nb = $urandom_range(31, 11);
        else nb = $urandom_range(40, 32);
        send_recording(nb, gap_set[p]);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_threshold_edges();
    test_backpressure();
    test_random();
    drain();
    if (rate_q.size() != 0) begin
      errors++;
      $display("%0d rate items never arrived", rate_q.size());
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/bihr_pkg.sv
rtl/core/bihr_div.sv
rtl/core/beat_interval_heart_rate.sv
rtl/core/bihr_check.sv
test/beat_interval_heart_rate_tb.sv
